// ===== rtl/csrgm_pkg.sv =====
`timescale 1ns / 1ps
package csrgm_pkg;

  localparam int MAX_NODES   = 256;
  localparam int MAX_ENTRIES = 1024;

  localparam int ID_W   = 8;
  localparam int SLOT_W = 10;
  localparam int NCNT_W = 9;
  localparam int ECNT_W = 11;
  localparam int RS_AW  = $clog2(MAX_NODES + 1);
  localparam int NB_AW  = $clog2(MAX_ENTRIES);

  localparam logic [2:0] OP_ADD_NODE = 3'd0;
  localparam logic [2:0] OP_DEL_NODE = 3'd1;
  localparam logic [2:0] OP_ADD_EDGE = 3'd2;
  localparam logic [2:0] OP_DEL_EDGE = 3'd3;
  localparam logic [2:0] OP_READ     = 3'd4;

  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_BAD  = 2'd1;
  localparam logic [1:0] ST_FULL = 2'd2;

  typedef struct packed {
    logic [2:0]        op;
    logic [ID_W-1:0]   node_a;
    logic [ID_W-1:0]   node_b;
    logic [SLOT_W-1:0] slot;
  } in_item_t;

  typedef struct packed {
    logic [1:0]        status;
    logic [NCNT_W-1:0] node_count;
    logic [ECNT_W-1:0] edge_count;
    logic [ECNT_W-1:0] row_begin;
    logic [ECNT_W-1:0] row_finish;
    logic [ID_W-1:0]   neighbor;
  } out_item_t;

  typedef enum logic [5:0] {
    C_NOP,
    C_CAPTURE,
    C_SET_AB,
    C_SET_BA,
    C_RS_RD_FROM,
    C_LATCH_LO,
    C_LATCH_HI,
    C_SCAN_RD,
    C_SET_FOUND,
    C_INC_I,
    C_DN_RD,
    C_DN_WR,
    C_DEC_ENT,
    C_RS_RD_FROM1,
    C_INS_INIT,
    C_UP_RD,
    C_UP_WR,
    C_INS_WR,
    C_RA_RD,
    C_RA_INC,
    C_RA_DEC,
    C_GROW_A,
    C_GROW_B,
    C_GROW_WR,
    C_GROW_END,
    C_EDGE_INIT,
    C_TAKE_FWD,
    C_TAKE_BWD,
    C_DROP_INIT,
    C_DROP_RD,
    C_DROP_ROW,
    C_DROP_CP,
    C_DROP_NEXT,
    C_DROP_FIN,
    C_RD_SLOT,
    C_FIN_OK,
    C_FIN_BAD,
    C_FIN_FULL,
    C_PUSH
  } dp_cmd_t;

  typedef struct packed {
    logic [2:0] op;
    logic       a_big;
    logic       b_big;
    logic       a_lt_n;
    logic       b_lt_n;
    logic       a_eq_b;
    logic       fits;
    logic       fwd;
    logic       bwd;
    logic       more_i;
    logic       match;
    logic       dn_more;
    logic       up_more;
    logic       ra_more;
    logic       grow_more;
    logic       drop_more;
    logic       drop_skip;
    logic       out_free;
  } dp_stat_t;

endpackage

// ===== rtl/csrgm_datapath.sv =====
`timescale 1ns / 1ps
module csrgm_datapath import csrgm_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  dp_cmd_t   cmd,
  input  in_item_t  in_data,
  input  logic      out_stall,
  output logic      out_valid,
  output out_item_t out_data,
  output dp_stat_t  stat
);

  logic [ECNT_W-1:0] rs_mem [0:MAX_NODES];
  logic [ID_W-1:0]   nb_mem [0:MAX_ENTRIES-1];

  in_item_t          item_r;
  logic [NCNT_W-1:0] nodes_r;
  logic [ECNT_W-1:0] entries_r;
  logic [ID_W-1:0]   from_r;
  logic [ID_W-1:0]   to_r;
  logic [ID_W-1:0]   gid_r;
  logic [NCNT_W:0]   r_r;
  logic [ECNT_W-1:0] i_r;
  logic [ECNT_W-1:0] lo_r;
  logic [ECNT_W-1:0] hi_r;
  logic [ECNT_W-1:0] w_r;
  logic              found_r;
  logic              fwd_r;
  logic              bwd_r;
  out_item_t         res_r;
  out_item_t         out_r;
  logic              out_valid_r;

  logic [ECNT_W-1:0] rs_rd_r;
  logic              rs_zero_r;
  logic [ID_W-1:0]   nb_rd_r;
  logic [ECNT_W-1:0] rs_q;

  logic [RS_AW-1:0]  rs_raddr;
  logic              rs_we;
  logic [RS_AW-1:0]  rs_waddr;
  logic [ECNT_W-1:0] rs_wdata;
  logic [NB_AW-1:0]  nb_raddr;
  logic              nb_we;
  logic [NB_AW-1:0]  nb_waddr;
  logic [ID_W-1:0]   nb_wdata;

  logic [ECNT_W-1:0] i_inc;
  logic [ECNT_W-1:0] i_dec;
  logic [ECNT_W:0]   need_sum;

  // row start 0 always reads as zero, whatever the memory word there holds
  assign rs_q  = rs_zero_r ? '0 : rs_rd_r;
  assign i_inc = i_r + 11'd1;
  assign i_dec = i_r - 11'd1;
  assign need_sum = {1'b0, entries_r} + {11'd0, fwd_r} + {11'd0, bwd_r};

  always_comb begin
    rs_raddr = '0;
    rs_we    = 1'b0;
    rs_waddr = '0;
    rs_wdata = '0;
    nb_raddr = '0;
    nb_we    = 1'b0;
    nb_waddr = '0;
    nb_wdata = '0;
    case (cmd)
      C_RS_RD_FROM: rs_raddr = {1'b0, from_r};
      C_LATCH_LO, C_RS_RD_FROM1: rs_raddr = {1'b0, from_r} + 9'd1;
      C_DROP_RD: rs_raddr = r_r[RS_AW-1:0] + 9'd1;
      C_RA_RD:   rs_raddr = r_r[RS_AW-1:0];
      C_GROW_WR: begin
        rs_we    = 1'b1;
        rs_waddr = r_r[RS_AW-1:0];
        rs_wdata = entries_r;
      end
      C_RA_INC: begin
        rs_we    = 1'b1;
        rs_waddr = r_r[RS_AW-1:0];
        rs_wdata = rs_q + 11'd1;
      end
      C_RA_DEC: begin
        rs_we    = 1'b1;
        rs_waddr = r_r[RS_AW-1:0];
        rs_wdata = rs_q - 11'd1;
      end
      C_DROP_ROW: begin
        rs_we    = 1'b1;
        rs_waddr = r_r[RS_AW-1:0];
        rs_wdata = w_r;
      end
      C_DROP_FIN: begin
        rs_we    = 1'b1;
        rs_waddr = nodes_r;
        rs_wdata = w_r;
      end
      C_SCAN_RD: nb_raddr = i_r[NB_AW-1:0];
      C_DN_RD:   nb_raddr = i_inc[NB_AW-1:0];
      C_UP_RD:   nb_raddr = i_dec[NB_AW-1:0];
      C_RD_SLOT: nb_raddr = item_r.slot;
      C_DN_WR, C_UP_WR: begin
        nb_we    = 1'b1;
        nb_waddr = i_r[NB_AW-1:0];
        nb_wdata = nb_rd_r;
      end
      C_INS_WR: begin
        nb_we    = 1'b1;
        nb_waddr = hi_r[NB_AW-1:0];
        nb_wdata = to_r;
      end
      C_DROP_CP: begin
        nb_we    = (nb_rd_r != item_r.node_a);
        nb_waddr = w_r[NB_AW-1:0];
        nb_wdata = nb_rd_r;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rs_we) begin
      rs_mem[rs_waddr] <= rs_wdata;
    end
    rs_rd_r   <= rs_mem[rs_raddr];
    rs_zero_r <= (rs_raddr == '0);
    if (nb_we) begin
      nb_mem[nb_waddr] <= nb_wdata;
    end
    nb_rd_r <= nb_mem[nb_raddr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      nodes_r     <= '0;
      entries_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd == C_PUSH) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
      case (cmd)
        C_CAPTURE: item_r <= in_data;
        C_SET_AB: begin
          from_r <= item_r.node_a;
          to_r   <= item_r.node_b;
        end
        C_SET_BA: begin
          from_r <= item_r.node_b;
          to_r   <= item_r.node_a;
        end
        C_LATCH_LO: lo_r <= rs_q;
        C_LATCH_HI: begin
          hi_r    <= rs_q;
          i_r     <= lo_r;
          found_r <= 1'b0;
        end
        C_SET_FOUND: found_r <= 1'b1;
        C_INC_I, C_DN_WR: i_r <= i_inc;
        C_DEC_ENT: begin
          entries_r <= entries_r - 11'd1;
          r_r       <= {2'b0, from_r} + 10'd1;
        end
        C_INS_INIT: begin
          hi_r <= rs_q;
          i_r  <= entries_r;
        end
        C_UP_WR: i_r <= i_dec;
        C_INS_WR: begin
          entries_r <= entries_r + 11'd1;
          r_r       <= {2'b0, from_r} + 10'd1;
        end
        C_RA_INC, C_RA_DEC, C_GROW_WR: r_r <= r_r + 10'd1;
        C_GROW_A: begin
          gid_r <= item_r.node_a;
          r_r   <= {1'b0, nodes_r} + 10'd1;
        end
        C_GROW_B: begin
          gid_r <= item_r.node_b;
          r_r   <= {1'b0, nodes_r} + 10'd1;
        end
        C_GROW_END: begin
          if ({1'b0, gid_r} >= nodes_r) begin
            nodes_r <= {1'b0, gid_r} + 9'd1;
          end
        end
        C_EDGE_INIT: begin
          fwd_r <= 1'b1;
          bwd_r <= (item_r.node_a != item_r.node_b);
        end
        C_TAKE_FWD: fwd_r <= !found_r;
        C_TAKE_BWD: bwd_r <= !found_r;
        C_DROP_INIT: begin
          w_r  <= '0;
          lo_r <= '0;
          r_r  <= '0;
        end
        C_DROP_ROW: begin
          hi_r <= rs_q;
          i_r  <= lo_r;
        end
        C_DROP_CP: begin
          if (nb_rd_r != item_r.node_a) begin
            w_r <= w_r + 11'd1;
          end
          i_r <= i_inc;
        end
        C_DROP_NEXT: begin
          lo_r <= hi_r;
          r_r  <= r_r + 10'd1;
        end
        C_DROP_FIN: entries_r <= w_r;
        C_FIN_OK: begin
          res_r.status     <= ST_OK;
          res_r.node_count <= nodes_r;
          res_r.edge_count <= entries_r;
          if (item_r.op == OP_READ) begin
            res_r.row_begin  <= lo_r;
            res_r.row_finish <= hi_r;
            res_r.neighbor   <= ({1'b0, item_r.slot} < entries_r) ? nb_rd_r : '0;
          end else begin
            res_r.row_begin  <= '0;
            res_r.row_finish <= '0;
            res_r.neighbor   <= '0;
          end
        end
        C_FIN_BAD, C_FIN_FULL: begin
          res_r.status     <= (cmd == C_FIN_FULL) ? ST_FULL : ST_BAD;
          res_r.node_count <= nodes_r;
          res_r.edge_count <= entries_r;
          res_r.row_begin  <= '0;
          res_r.row_finish <= '0;
          res_r.neighbor   <= '0;
        end
        C_PUSH: out_r <= res_r;
        default: ;
      endcase
    end
  end

  always_comb begin
    stat.op        = item_r.op;
    stat.a_big     = ({1'b0, item_r.node_a} >= NCNT_W'(MAX_NODES));
    stat.b_big     = ({1'b0, item_r.node_b} >= NCNT_W'(MAX_NODES));
    stat.a_lt_n    = ({1'b0, item_r.node_a} < nodes_r);
    stat.b_lt_n    = ({1'b0, item_r.node_b} < nodes_r);
    stat.a_eq_b    = (item_r.node_a == item_r.node_b);
    stat.fits      = (need_sum <= 12'(MAX_ENTRIES));
    stat.fwd       = fwd_r;
    stat.bwd       = bwd_r;
    stat.more_i    = (i_r < hi_r);
    stat.match     = (nb_rd_r == to_r);
    stat.dn_more   = (i_inc < entries_r);
    stat.up_more   = (i_r > hi_r);
    stat.ra_more   = (r_r <= {1'b0, nodes_r});
    stat.grow_more = (r_r <= ({2'b0, gid_r} + 10'd1));
    stat.drop_more = (r_r < {1'b0, nodes_r});
    stat.drop_skip = (r_r == {2'b0, item_r.node_a});
    stat.out_free  = !out_valid_r || !out_stall;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

// ===== rtl/csrgm_ctrl.sv =====
`timescale 1ns / 1ps
module csrgm_ctrl import csrgm_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  input  dp_stat_t stat,
  output dp_cmd_t  cmd,
  output logic     in_stall
);

  typedef enum logic [4:0] {
    S_IDLE, S_DISP,
    S_RL0, S_RL1, S_RL2,
    S_SC0, S_SC1,
    S_DS0, S_DS1,
    S_IN0, S_IN1, S_IN2, S_IN3,
    S_RA0, S_RA1,
    S_GROW,
    S_DR0, S_DR1, S_DR2, S_DR3,
    S_DONE
  } state_t;

  typedef enum logic [1:0] {RT_HAS, RT_DEL, RT_READ, RT_INS} rt_t;

  state_t     state_r, state_nxt;
  rt_t        rt_r, rt_nxt;
  logic [3:0] phase_r, phase_nxt;
  logic       stall_r, stall_nxt;

  always_comb begin
    state_nxt = state_r;
    rt_nxt    = rt_r;
    phase_nxt = phase_r;
    cmd       = C_NOP;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd       = C_CAPTURE;
          state_nxt = S_DISP;
          phase_nxt = 4'd0;
        end
      end
      S_DISP: begin
        case (stat.op)
          OP_ADD_NODE: begin
            if (phase_r == 4'd0) begin
              if (stat.a_big) begin
                cmd = C_FIN_BAD; state_nxt = S_DONE;
              end else begin
                cmd = C_GROW_A; state_nxt = S_GROW; phase_nxt = 4'd1;
              end
            end else begin
              cmd = C_FIN_OK; state_nxt = S_DONE;
            end
          end
          OP_DEL_NODE: begin
            if (phase_r == 4'd0) begin
              if (!stat.a_lt_n) begin
                cmd = C_FIN_BAD; state_nxt = S_DONE;
              end else begin
                cmd = C_DROP_INIT; state_nxt = S_DR0; phase_nxt = 4'd1;
              end
            end else begin
              cmd = C_FIN_OK; state_nxt = S_DONE;
            end
          end
          OP_ADD_EDGE: begin
            case (phase_r)
              4'd0: begin
                if (stat.a_big || stat.b_big) begin
                  cmd = C_FIN_BAD; state_nxt = S_DONE;
                end else begin
                  cmd       = C_EDGE_INIT;
                  phase_nxt = (stat.a_lt_n && stat.b_lt_n) ? 4'd1 : 4'd5;
                end
              end
              4'd1: begin
                cmd = C_SET_AB; rt_nxt = RT_HAS; state_nxt = S_RL0; phase_nxt = 4'd2;
              end
              4'd2: begin
                cmd = C_TAKE_FWD; phase_nxt = 4'd3;
              end
              4'd3: begin
                if (!stat.a_eq_b) begin
                  cmd = C_SET_BA; rt_nxt = RT_HAS; state_nxt = S_RL0; phase_nxt = 4'd4;
                end else begin
                  phase_nxt = 4'd5;
                end
              end
              4'd4: begin
                cmd = C_TAKE_BWD; phase_nxt = 4'd5;
              end
              4'd5: begin
                if (!stat.fits) begin
                  cmd = C_FIN_FULL; state_nxt = S_DONE;
                end else begin
                  cmd = C_GROW_A; state_nxt = S_GROW; phase_nxt = 4'd6;
                end
              end
              4'd6: begin
                cmd = C_GROW_B; state_nxt = S_GROW; phase_nxt = 4'd7;
              end
              4'd7: begin
                phase_nxt = 4'd8;
                if (stat.fwd) begin
                  cmd = C_SET_AB; rt_nxt = RT_INS; state_nxt = S_IN0;
                end
              end
              4'd8: begin
                phase_nxt = 4'd9;
                if (stat.bwd) begin
                  cmd = C_SET_BA; rt_nxt = RT_INS; state_nxt = S_IN0;
                end
              end
              default: begin
                cmd = C_FIN_OK; state_nxt = S_DONE;
              end
            endcase
          end
          OP_DEL_EDGE: begin
            case (phase_r)
              4'd0: begin
                if (!(stat.a_lt_n && stat.b_lt_n)) begin
                  cmd = C_FIN_BAD; state_nxt = S_DONE;
                end else begin
                  cmd = C_SET_AB; rt_nxt = RT_DEL; state_nxt = S_RL0; phase_nxt = 4'd1;
                end
              end
              4'd1: begin
                cmd = C_SET_BA; rt_nxt = RT_DEL; state_nxt = S_RL0; phase_nxt = 4'd2;
              end
              default: begin
                cmd = C_FIN_OK; state_nxt = S_DONE;
              end
            endcase
          end
          OP_READ: begin
            case (phase_r)
              4'd0: begin
                if (!stat.a_lt_n) begin
                  cmd = C_FIN_BAD; state_nxt = S_DONE;
                end else begin
                  cmd = C_SET_AB; rt_nxt = RT_READ; state_nxt = S_RL0; phase_nxt = 4'd1;
                end
              end
              4'd1: begin
                cmd = C_RD_SLOT; phase_nxt = 4'd2;
              end
              default: begin
                cmd = C_FIN_OK; state_nxt = S_DONE;
              end
            endcase
          end
          default: begin
            cmd = C_FIN_BAD; state_nxt = S_DONE;
          end
        endcase
      end
      // row bounds of from
      S_RL0: begin cmd = C_RS_RD_FROM; state_nxt = S_RL1; end
      S_RL1: begin cmd = C_LATCH_LO;   state_nxt = S_RL2; end
      S_RL2: begin
        cmd       = C_LATCH_HI;
        state_nxt = (rt_r == RT_READ) ? S_DISP : S_SC0;
      end
      S_SC0: begin
        if (stat.more_i) begin
          cmd = C_SCAN_RD; state_nxt = S_SC1;
        end else begin
          state_nxt = S_DISP;
        end
      end
      S_SC1: begin
        if (stat.match) begin
          if (rt_r == RT_HAS) begin
            cmd = C_SET_FOUND; state_nxt = S_DISP;
          end else begin
            state_nxt = S_DS0;
          end
        end else begin
          cmd = C_INC_I; state_nxt = S_SC0;
        end
      end
      // close the gap left by a deleted item
      S_DS0: begin
        if (stat.dn_more) begin
          cmd = C_DN_RD; state_nxt = S_DS1;
        end else begin
          cmd = C_DEC_ENT; state_nxt = S_RA0;
        end
      end
      S_DS1: begin cmd = C_DN_WR; state_nxt = S_DS0; end
      // open a gap at the end of the row, top down
      S_IN0: begin cmd = C_RS_RD_FROM1; state_nxt = S_IN1; end
      S_IN1: begin cmd = C_INS_INIT;    state_nxt = S_IN2; end
      S_IN2: begin
        if (stat.up_more) begin
          cmd = C_UP_RD; state_nxt = S_IN3;
        end else begin
          cmd = C_INS_WR; state_nxt = S_RA0;
        end
      end
      S_IN3: begin cmd = C_UP_WR; state_nxt = S_IN2; end
      S_RA0: begin
        if (stat.ra_more) begin
          cmd = C_RA_RD; state_nxt = S_RA1;
        end else begin
          state_nxt = S_DISP;
        end
      end
      S_RA1: begin
        cmd       = (rt_r == RT_INS) ? C_RA_INC : C_RA_DEC;
        state_nxt = S_RA0;
      end
      S_GROW: begin
        if (stat.grow_more) begin
          cmd = C_GROW_WR;
        end else begin
          cmd = C_GROW_END; state_nxt = S_DISP;
        end
      end
      // compacting pass over all rows
      S_DR0: begin
        if (stat.drop_more) begin
          cmd = C_DROP_RD; state_nxt = S_DR1;
        end else begin
          cmd = C_DROP_FIN; state_nxt = S_DISP;
        end
      end
      S_DR1: begin cmd = C_DROP_ROW; state_nxt = S_DR2; end
      S_DR2: begin
        if (!stat.drop_skip && stat.more_i) begin
          cmd = C_SCAN_RD; state_nxt = S_DR3;
        end else begin
          cmd = C_DROP_NEXT; state_nxt = S_DR0;
        end
      end
      S_DR3: begin cmd = C_DROP_CP; state_nxt = S_DR2; end
      S_DONE: begin
        if (stat.out_free) begin
          cmd = C_PUSH; state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
    stall_nxt = (state_nxt != S_IDLE);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      rt_r    <= RT_HAS;
      phase_r <= 4'd0;
      stall_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      rt_r    <= rt_nxt;
      phase_r <= phase_nxt;
      stall_r <= stall_nxt;
    end
  end

  assign in_stall = stall_r;

endmodule

// ===== rtl/csr_undirected_graph_mutator_unit.sv =====
`timescale 1ns / 1ps
// Undirected graph store in compressed-sparse-row form.
// Input channel (in_valid / in_stall / in_data) takes one operation item:
// add node, remove node, add edge, remove edge or read row. The result
// channel (out_valid / out_stall / out_data) returns exactly one item per
// operation, in order, with status and the node and entry counts after it.
// One operation is worked at a time; in_stall stays high from the cycle
// after an item is taken until its result sits in the output register.
// A read fetches the row bounds and one slot; add node writes a row
// start for each new row; edge ops scan rows entry by entry, then move
// the neighbor array and row starts, and remove node sweeps all rows
// and entries. The running time is set by the single read and write
// port of each of the two memories.
// A result waiting under out_stall holds; the next item is still taken.
// Reset empties the store (zero nodes, zero entries); no clearing pass.
module csr_undirected_graph_mutator_unit import csrgm_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_data
);

  dp_cmd_t  cmd;
  dp_stat_t stat;

  csrgm_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .stat     (stat),
    .cmd      (cmd),
    .in_stall (in_stall)
  );

  csrgm_datapath u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .in_data   (in_data),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .out_data  (out_data),
    .stat      (stat)
  );

endmodule
